// ----- design/cabb_pkg.sv -----
// ----------------------------------------------------------------------------
// cabb_pkg
// Shared sizes, register indexes and limits for the assignment search core.
// ----------------------------------------------------------------------------
package cabb_pkg;

  localparam int unsigned MAX_STORES   = 16;
  localparam int unsigned MAX_PRODUCTS = 64;
  localparam int unsigned PRICE_W      = 16;
  localparam int unsigned STORE_W      = 4;
  localparam int unsigned PROD_W       = 6;
  localparam int unsigned CHOICE_W     = 5;
  localparam int unsigned NS_W         = 5;
  localparam int unsigned NP_W         = 7;
  localparam int unsigned CAP_W        = 3;
  localparam int unsigned COST_W       = 22;
  localparam int unsigned CNT_W        = 40;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 7;

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic [NS_W-1:0]  NS_RESET  = NS_W'(MAX_STORES);
  localparam logic [NP_W-1:0]  NP_RESET  = NP_W'(MAX_PRODUCTS);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STORES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PRODUCTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_CAP    = 2'd2;

endpackage

// ----- design/cabb_if.sv -----
// ----------------------------------------------------------------------------
// cabb_in_if / cabb_out_if
// Valid/ready channels for price loads and search results.
// ----------------------------------------------------------------------------
interface cabb_in_if;
  logic                              valid;
  logic                              ready;
  logic [cabb_pkg::STORE_W-1:0]      store_index;
  logic [cabb_pkg::PROD_W-1:0]       product_index;
  logic [cabb_pkg::PRICE_W-1:0]      price;
  logic                              last_price;

  modport source (output valid, store_index, product_index, price, last_price,
                  input ready);
  modport sink   (input valid, store_index, product_index, price, last_price,
                  output ready);
endinterface

interface cabb_out_if;
  logic                              valid;
  logic                              ready;
  logic [cabb_pkg::COST_W-1:0]       min_cost;
  logic                              found;
  logic [cabb_pkg::CNT_W-1:0]        node_count;

  modport source (output valid, min_cost, found, node_count, input ready);
  modport sink   (input valid, min_cost, found, node_count, output ready);
endinterface

// ----- design/cabb_ram.sv -----
// ----------------------------------------------------------------------------
// cabb_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cabb_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/capacitated_assignment_branch_bound_core.sv -----
// ----------------------------------------------------------------------------
// capacitated_assignment_branch_bound_core
// Loads a price table, then runs a depth-first branch-and-bound assignment
// of products to capacity-limited stores and reports the cheapest total.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  in_i    | in  | one price load (store, product, price, last flag)
//  out_o   | out | one search result (min cost, found, node count)
//  cfg     | in  | register write (index, data), always taken
//
//  A load writes the price RAM in S_IDLE and updates the column minimum
//  RAM in S_LMIN. The last load adds a bound sweep over the products,
//  then each search step runs S_EVAL and, as needed, S_ADD and S_CMP or
//  S_POP_PR and S_POP_UPD, since the price RAM read is registered. No
//  input is taken until the result transaction completes. Reset is
//  asynchronous; the price table keeps its contents across results.
// ----------------------------------------------------------------------------
module capacitated_assignment_branch_bound_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cabb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cabb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  cabb_in_if.sink                          in_i,
  cabb_out_if.source                       out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_LMIN, S_SFX_RD, S_SFX_ACC, S_EVAL, S_ADD, S_CMP,
    S_POP_PR, S_POP_UPD, S_DONE
  } state_e;

  state_e state_q;

  logic [cabb_pkg::NS_W-1:0]   ns_q;
  logic [cabb_pkg::NP_W-1:0]   np_q;
  logic [cabb_pkg::CAP_W-1:0]  cap_q;

  logic [cabb_pkg::PROD_W-1:0]   prod_q;
  logic [cabb_pkg::PRICE_W-1:0]  price_q;
  logic                          last_q;

  logic [cabb_pkg::MAX_PRODUCTS-1:0] cm_vld_q;
  logic                              cm_vld_rd_q;
  logic [cabb_pkg::NP_W-1:0]         sfx_k_q;
  logic [cabb_pkg::COST_W-1:0]       acc_q;

  logic [cabb_pkg::PROD_W-1:0]   level_q;
  logic [cabb_pkg::CHOICE_W-1:0] choice_q;
  logic [cabb_pkg::COST_W-1:0]   run_q;
  logic [cabb_pkg::COST_W:0]     psum_q;
  logic [cabb_pkg::COST_W-1:0]   best_q;
  logic [cabb_pkg::CNT_W-1:0]    count_q;
  logic [cabb_pkg::CAP_W-1:0]    usage_q [cabb_pkg::MAX_STORES];

  logic                          out_valid_q;
  logic [cabb_pkg::COST_W-1:0]   out_cost_q;
  logic                          out_found_q;
  logic [cabb_pkg::CNT_W-1:0]    out_count_q;

  // RAM ports
  logic [cabb_pkg::STORE_W+cabb_pkg::PROD_W-1:0] pr_raddr;
  logic [cabb_pkg::PRICE_W-1:0]  pr_rdata;
  logic                          cm_we;
  logic [cabb_pkg::PROD_W-1:0]   cm_raddr;
  logic [cabb_pkg::PRICE_W-1:0]  cm_rdata;
  logic                          sb_we;
  logic [cabb_pkg::COST_W-1:0]   sb_wdata;
  logic [cabb_pkg::COST_W-1:0]   sb_rdata;
  logic                          st_we;
  logic [cabb_pkg::CHOICE_W-1:0] st_rdata;

  logic                          in_acc;
  logic [cabb_pkg::PRICE_W-1:0]  cm_min;
  logic [cabb_pkg::COST_W:0]     acc_sum;
  logic [cabb_pkg::COST_W:0]     add_sum;
  logic [cabb_pkg::COST_W:0]     bnd_sum;
  logic [cabb_pkg::PROD_W-1:0]   level_dn;
  logic [cabb_pkg::STORE_W-1:0]  use_idx;
  logic                          last_prod;
  logic [cabb_pkg::CNT_W-1:0]    count_inc;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.min_cost   = out_cost_q;
  assign out_o.found      = out_found_q;
  assign out_o.node_count = out_count_q;

  assign level_dn  = level_q - 1'b1;
  assign use_idx   = (state_q == S_POP_UPD) ? st_rdata[cabb_pkg::STORE_W-1:0]
                                            : choice_q[cabb_pkg::STORE_W-1:0];
  assign pr_raddr  = (state_q == S_POP_PR)
                     ? {st_rdata[cabb_pkg::STORE_W-1:0], level_dn}
                     : {choice_q[cabb_pkg::STORE_W-1:0], level_q};
  assign cm_raddr  = (state_q == S_IDLE) ? in_i.product_index
                                         : cabb_pkg::PROD_W'(sfx_k_q - 1'b1);
  assign cm_min    = cm_vld_rd_q ? cm_rdata : '1;
  assign cm_we     = (state_q == S_LMIN) && (price_q < cm_min);
  assign acc_sum   = {1'b0, acc_q} + (cabb_pkg::COST_W+1)'(cm_min);
  assign sb_wdata  = acc_sum[cabb_pkg::COST_W] ? cabb_pkg::COST_MAX
                                               : acc_sum[cabb_pkg::COST_W-1:0];
  assign sb_we     = (state_q == S_SFX_ACC);
  assign add_sum   = {1'b0, run_q} + (cabb_pkg::COST_W+1)'(pr_rdata);
  assign bnd_sum   = {1'b0, sb_rdata} + {1'b0, psum_q[cabb_pkg::COST_W-1:0]};
  assign last_prod = (cabb_pkg::NP_W'(level_q) + 1'b1) == np_q;
  assign count_inc = (count_q != cabb_pkg::CNT_MAX) ? count_q + 1'b1 : count_q;
  assign st_we     = (state_q == S_CMP) && !psum_q[cabb_pkg::COST_W]
                     && (bnd_sum < {1'b0, best_q});

  cabb_ram #(.DEPTH(cabb_pkg::MAX_STORES * cabb_pkg::MAX_PRODUCTS),
             .WIDTH(cabb_pkg::PRICE_W)) u_price (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i ({in_i.store_index, in_i.product_index}),
    .wdata_i (in_i.price),
    .raddr_i (pr_raddr),
    .rdata_o (pr_rdata)
  );

  cabb_ram #(.DEPTH(cabb_pkg::MAX_PRODUCTS), .WIDTH(cabb_pkg::PRICE_W)) u_colmin (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (prod_q),
    .wdata_i (price_q),
    .raddr_i (cm_raddr),
    .rdata_o (cm_rdata)
  );

  cabb_ram #(.DEPTH(cabb_pkg::MAX_PRODUCTS), .WIDTH(cabb_pkg::COST_W)) u_bound (
    .clk_i   (clk_i),
    .we_i    (sb_we),
    .waddr_i (sfx_k_q[cabb_pkg::PROD_W-1:0]),
    .wdata_i (sb_wdata),
    .raddr_i (level_q + 1'b1),
    .rdata_o (sb_rdata)
  );

  cabb_ram #(.DEPTH(cabb_pkg::MAX_PRODUCTS), .WIDTH(cabb_pkg::CHOICE_W)) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (level_q),
    .wdata_i (choice_q),
    .raddr_i (level_dn),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q <= cabb_pkg::NS_RESET;
      np_q <= cabb_pkg::NP_RESET;
      cap_q <= cabb_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cabb_pkg::REG_NUM_STORES: begin
          if (cfg_data_i[cabb_pkg::NS_W-1:0] == '0) ns_q <= cabb_pkg::NS_W'(1);
          else if (cfg_data_i[cabb_pkg::NS_W-1:0] > cabb_pkg::NS_RESET)
            ns_q <= cabb_pkg::NS_RESET;
          else ns_q <= cfg_data_i[cabb_pkg::NS_W-1:0];
        end
        cabb_pkg::REG_NUM_PRODUCTS: begin
          if (cfg_data_i == '0) np_q <= cabb_pkg::NP_W'(1);
          else if (cfg_data_i > cabb_pkg::NP_RESET) np_q <= cabb_pkg::NP_RESET;
          else np_q <= cfg_data_i;
        end
        cabb_pkg::REG_STORE_CAP: cap_q <= cfg_data_i[cabb_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prod_q  <= in_i.product_index;
      price_q <= in_i.price;
      last_q  <= in_i.last_price;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cm_vld_q    <= '0;
      cm_vld_rd_q <= 1'b0;
      sfx_k_q     <= '0;
      acc_q       <= '0;
      level_q     <= '0;
      choice_q    <= '0;
      run_q       <= '0;
      psum_q      <= '0;
      best_q      <= cabb_pkg::COST_MAX;
      count_q     <= '0;
      for (int s = 0; s < cabb_pkg::MAX_STORES; s++) usage_q[s] <= '0;
      out_valid_q <= 1'b0;
      out_cost_q  <= '0;
      out_found_q <= 1'b0;
      out_count_q <= '0;
    end else begin
      cm_vld_rd_q <= cm_vld_q[cm_raddr];
      case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= S_LMIN;
        end
        S_LMIN: begin
          if (cm_we) cm_vld_q[prod_q] <= 1'b1;
          if (last_q) begin
            sfx_k_q <= np_q;
            acc_q   <= '0;
            state_q <= S_SFX_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SFX_RD: begin
          sfx_k_q <= sfx_k_q - 1'b1;
          state_q <= S_SFX_ACC;
        end
        S_SFX_ACC: begin
          acc_q <= sb_wdata;
          if (sfx_k_q == '0) begin
            level_q  <= '0;
            choice_q <= '0;
            run_q    <= '0;
            best_q   <= cabb_pkg::COST_MAX;
            count_q  <= cabb_pkg::CNT_W'(1);
            for (int s = 0; s < cabb_pkg::MAX_STORES; s++) usage_q[s] <= '0;
            state_q  <= S_EVAL;
          end else begin
            state_q <= S_SFX_RD;
          end
        end
        S_EVAL: begin
          if (choice_q >= ns_q) begin
            if (level_q == '0) begin
              out_valid_q <= 1'b1;
              out_found_q <= (best_q != cabb_pkg::COST_MAX);
              out_cost_q  <= (best_q != cabb_pkg::COST_MAX) ? best_q : '0;
              out_count_q <= count_q;
              state_q     <= S_DONE;
            end else begin
              state_q <= S_POP_PR;
            end
          end else if (usage_q[use_idx] < cap_q) begin
            state_q <= S_ADD;
          end else begin
            choice_q <= choice_q + 1'b1;
          end
        end
        S_ADD: begin
          if (last_prod) begin
            if (add_sum < {1'b0, best_q}) best_q <= add_sum[cabb_pkg::COST_W-1:0];
            choice_q <= choice_q + 1'b1;
            state_q  <= S_EVAL;
          end else begin
            psum_q  <= add_sum;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (st_we) begin
            level_q          <= level_q + 1'b1;
            choice_q         <= '0;
            run_q            <= psum_q[cabb_pkg::COST_W-1:0];
            usage_q[use_idx] <= usage_q[use_idx] + 1'b1;
            count_q          <= count_inc;
          end else begin
            choice_q <= choice_q + 1'b1;
          end
          state_q <= S_EVAL;
        end
        S_POP_PR: begin
          state_q <= S_POP_UPD;
        end
        S_POP_UPD: begin
          run_q            <= run_q - cabb_pkg::COST_W'(pr_rdata);
          usage_q[use_idx] <= usage_q[use_idx] - 1'b1;
          choice_q         <= st_rdata + 1'b1;
          level_q          <= level_dn;
          state_q          <= S_EVAL;
        end
        S_DONE: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            cm_vld_q    <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_load_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_i.ready)
    else $error("input ready while result pending");
  a_cost_zero_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_cost_q == '0))
    else $error("nonzero cost without feasible assignment");
  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (cabb_pkg::NP_W'(level_q) < np_q))
    else $error("search level beyond product count");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_count_q != '0))
    else $error("root node not counted");
`endif

endmodule

// ----- sim/cabb_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cabb_checker
// Watches the register port and both channels of the assignment search core,
// keeps its own copy of the price table, minima and registers, predicts the
// result of each search and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module cabb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cabb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cabb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cabb_in_if                              in_i,
  cabb_out_if                             out_o,
  output int                              fail_count_o,
  output int                              pending_o
);

  typedef struct packed {
    logic [cabb_pkg::COST_W-1:0] min_cost;
    logic                        found;
    logic [cabb_pkg::CNT_W-1:0]  node_count;
  } search_result_t;

  logic [cabb_pkg::PRICE_W-1:0] prices [cabb_pkg::MAX_STORES][cabb_pkg::MAX_PRODUCTS];
  logic [cabb_pkg::PRICE_W-1:0] col_min [cabb_pkg::MAX_PRODUCTS];
  int unsigned                  stores_q, products_q, cap_q;
  search_result_t               expected_q [$];

  assign pending_o = expected_q.size();

  function automatic search_result_t solve_assignment();
    search_result_t r;
    longint unsigned bound [cabb_pkg::MAX_PRODUCTS];
    int unsigned     usage [cabb_pkg::MAX_STORES];
    int unsigned     stk [cabb_pkg::MAX_PRODUCTS];
    longint unsigned acc, run, best, cnt;
    int unsigned     k, i, j;
    acc = 0;
    for (int p = int'(products_q) - 1; p >= 0; p--) begin
      acc += col_min[p];
      if (acc > cabb_pkg::COST_MAX) acc = cabb_pkg::COST_MAX;
      bound[p] = acc;
    end
    foreach (usage[s]) usage[s] = 0;
    run = 0;
    best = cabb_pkg::COST_MAX;
    k = 0;
    stk[0] = 0;
    cnt = 1;
    forever begin
      i = stk[k];
      if (i >= stores_q) begin
        if (k == 0) break;
        k = k - 1;
        j = stk[k];
        run -= prices[j][k];
        usage[j]--;
        stk[k] = j + 1;
        continue;
      end
      if (usage[i] < cap_q) begin
        run += prices[i][k];
        usage[i]++;
        if (k + 1 == products_q) begin
          if (run < best) best = run;
        end else if (bound[k+1] + run < best) begin
          k = k + 1;
          stk[k] = 0;
          if (cnt < cabb_pkg::CNT_MAX) cnt++;
          continue;
        end
        run -= prices[i][k];
        usage[i]--;
      end
      stk[k] = i + 1;
    end
    r.found      = best < cabb_pkg::COST_MAX;
    r.min_cost   = r.found ? cabb_pkg::COST_W'(best) : '0;
    r.node_count = cabb_pkg::CNT_W'(cnt);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count_o++;
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    search_result_t e;
    if (!rst_ni) begin
      stores_q     = cabb_pkg::MAX_STORES;
      products_q   = cabb_pkg::MAX_PRODUCTS;
      cap_q        = cabb_pkg::CAP_RESET;
      fail_count_o = 0;
      foreach (col_min[p]) col_min[p] = '1;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cabb_pkg::REG_NUM_STORES: begin
            stores_q = cfg_data_i[cabb_pkg::NS_W-1:0];
            if (stores_q < 1) stores_q = 1;
            if (stores_q > cabb_pkg::MAX_STORES) stores_q = cabb_pkg::MAX_STORES;
          end
          cabb_pkg::REG_NUM_PRODUCTS: begin
            products_q = cfg_data_i[cabb_pkg::NP_W-1:0];
            if (products_q < 1) products_q = 1;
            if (products_q > cabb_pkg::MAX_PRODUCTS) products_q = cabb_pkg::MAX_PRODUCTS;
          end
          cabb_pkg::REG_STORE_CAP: cap_q = cfg_data_i[cabb_pkg::CAP_W-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        prices[in_i.store_index][in_i.product_index] = in_i.price;
        if (in_i.price < col_min[in_i.product_index])
          col_min[in_i.product_index] = in_i.price;
        if (in_i.last_price) begin
          expected_q.push_back(solve_assignment());
          foreach (col_min[p]) col_min[p] = '1;
        end
      end
      if (out_o.valid && out_o.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_o.min_cost, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_o.min_cost !== e.min_cost)
            report_mismatch("min_cost", out_o.min_cost, e.min_cost);
          if (out_o.found !== e.found)
            report_mismatch("found", out_o.found, e.found);
          if (out_o.node_count !== e.node_count)
            report_mismatch("node_count", out_o.node_count, e.node_count);
        end
      end
    end
  end

endmodule

// ----- sim/capacitated_assignment_branch_bound_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capacitated_assignment_branch_bound_core_tb
// Drives price loads and register settings into the assignment search core,
// with random gaps and a long output stall, and gives the final verdict from
// the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module capacitated_assignment_branch_bound_core_tb;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned LOAD_TARGET = 1100;

  typedef struct {
    logic [cabb_pkg::STORE_W-1:0] store;
    logic [cabb_pkg::PROD_W-1:0]  product;
    logic [cabb_pkg::PRICE_W-1:0] price;
  } price_load_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [cabb_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [cabb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  int                              fail_count;
  int                              pending;
  bit                              burst;
  bit                              loaded [cabb_pkg::MAX_STORES][cabb_pkg::MAX_PRODUCTS];

  cabb_in_if  in_if ();
  cabb_out_if out_if ();

  capacitated_assignment_branch_bound_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  cabb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_if),
    .out_o        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.store_index = '0;
    in_if.product_index = '0;
    in_if.price = '0;
    in_if.last_price = 1'b0;
    out_if.ready = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  // hold off the first result for a long stretch so the core backs up
  initial begin
    int gap;
    @(posedge clk_i iff rst_ni);
    repeat (400) @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  task automatic send_load(input price_load_t ld, input bit last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.store_index   <= ld.store;
    in_if.product_index <= ld.product;
    in_if.price         <= ld.price;
    in_if.last_price    <= last;
    do @(posedge clk_i); while (!in_if.ready);
    loaded[ld.store][ld.product] = 1'b1;
  endtask

  task automatic write_regs(input int unsigned ns, input int unsigned np,
                            input int unsigned cap);
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= cabb_pkg::REG_NUM_STORES;
    cfg_data_i <= cabb_pkg::CFG_DATA_W'(ns);
    @(posedge clk_i);
    cfg_idx_i <= cabb_pkg::REG_NUM_PRODUCTS;
    cfg_data_i <= cabb_pkg::CFG_DATA_W'(np);
    @(posedge clk_i);
    cfg_idx_i <= cabb_pkg::REG_STORE_CAP;
    cfg_data_i <= cabb_pkg::CFG_DATA_W'(cap);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    price_load_t     loads [$];
    price_load_t     ld;
    int unsigned     ns, np, cap, ns_e, np_e, kind, sent, n;
    bit              all_loaded;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst = 1'b1;
    write_regs(2, 3, 2);
    send_load('{4'd15, 6'd63, 16'hAAAA}, 1'b0);
    send_load('{4'd0, 6'd0, 16'd0}, 1'b0);
    send_load('{4'd1, 6'd0, 16'hFFFF}, 1'b0);
    send_load('{4'd0, 6'd1, 16'hFFFF}, 1'b0);
    send_load('{4'd1, 6'd1, 16'd0}, 1'b0);
    send_load('{4'd0, 6'd2, 16'd1}, 1'b0);
    send_load('{4'd1, 6'd2, 16'd2}, 1'b1);
    send_load('{4'd1, 6'd2, 16'hFFFF}, 1'b1);
    send_load('{4'd0, 6'd1, 16'h5555}, 1'b1);
    write_regs(2, 3, 0);
    send_load('{4'd0, 6'd0, 16'd7}, 1'b1);
    write_regs(0, 0, 7);
    send_load('{4'd0, 6'd0, 16'hFFFF}, 1'b1);
    sent = 11;

    ns = 0;
    np = 0;
    cap = 7;
    while (sent < LOAD_TARGET) begin
      burst = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind != 9) begin
        if (kind <= 6) begin
          ns = $urandom_range(1, 4);
          np = $urandom_range(1, 5);
        end else if (kind == 7) begin
          ns = $urandom_range(9, 31);
          np = $urandom_range(1, 2);
        end else begin
          ns = $urandom_range(0, 2);
          np = $urandom_range(0, 1) ? $urandom_range(8, 14) : $urandom_range(15, 127);
        end
        cap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
        write_regs(ns, np, cap);
      end
      ns_e = clamp_count(ns, cabb_pkg::MAX_STORES);
      np_e = clamp_count(np, cabb_pkg::MAX_PRODUCTS);
      all_loaded = 1'b1;
      for (int s = 0; s < ns_e; s++)
        for (int p = 0; p < np_e; p++)
          if (!loaded[s][p]) all_loaded = 1'b0;
      loads.delete();
      if (all_loaded && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          ld.store = cabb_pkg::STORE_W'($urandom_range(0, ns_e - 1));
          ld.product = cabb_pkg::PROD_W'($urandom_range(0, np_e - 1));
          ld.price = cabb_pkg::PRICE_W'($urandom);
          loads.push_back(ld);
        end
      end else begin
        for (int s = 0; s < ns_e; s++)
          for (int p = 0; p < np_e; p++) begin
            ld.store = cabb_pkg::STORE_W'(s);
            ld.product = cabb_pkg::PROD_W'(p);
            ld.price = cabb_pkg::PRICE_W'($urandom);
            loads.push_back(ld);
          end
        loads.shuffle();
      end
      repeat ($urandom_range(0, 2)) begin
        ld.store = cabb_pkg::STORE_W'($urandom);
        ld.product = cabb_pkg::PROD_W'($urandom);
        ld.price = cabb_pkg::PRICE_W'($urandom);
        loads.push_front(ld);
      end
      foreach (loads[i]) send_load(loads[i], i == loads.size() - 1);
      sent += loads.size();
    end

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
